### hw/rtl/wse_pkg.sv
// ----------------------------------------------------------------------------
// wse_pkg
// Shared types and constants of the windowed SSIM engine: the request format
// of the bit-serial arithmetic unit and the fixed-point constants.
// ----------------------------------------------------------------------------
package wse_pkg;

	localparam int DATA_W = 64;
	localparam int STEP_W = 7;
	localparam int COMP_W = 18;
	localparam int OUT_W  = 18;
	localparam int MEAN_W = 17;

	localparam logic [DATA_W-1:0] C1_Q16      = 64'd426148;
	localparam logic [DATA_W-1:0] C2_Q16      = 64'd3835331;
	localparam logic [DATA_W-1:0] LUMA_R      = 64'd13933;
	localparam logic [DATA_W-1:0] LUMA_G      = 64'd46871;
	localparam logic [DATA_W-1:0] LUMA_B      = 64'd4732;
	localparam logic [DATA_W-1:0] LUMA_RND    = 64'd128;
	localparam logic [DATA_W-1:0] COLOR_RND   = 64'd127;
	// ceil(2^34 / 255), exact floor division for dividends below 2^26
	localparam logic [DATA_W-1:0] COLOR_RECIP = 64'd67372037;
	localparam logic [DATA_W-1:0] FRAC_ONE    = 64'd1 << 30;
	localparam logic [DATA_W-1:0] PROD_RND    = 64'd1 << 43;
	localparam logic [DATA_W-1:0] MEAN_MAX    = 64'd65536;

	localparam logic [STEP_W-1:0] STEPS_BYTE  = 7'd8;
	localparam logic [STEP_W-1:0] STEPS_CDIV  = 7'd26;
	localparam logic [STEP_W-1:0] STEPS_SQ    = 7'd18;
	localparam logic [STEP_W-1:0] STEPS_FRAC  = 7'd30;
	localparam logic [STEP_W-1:0] STEPS_PROD  = 7'd31;
	localparam logic [STEP_W-1:0] STEPS_MEAN  = 7'd40;
	localparam int                CDIV_SHIFT  = 34;
	localparam int                MEAN_SHIFT  = 24;

	typedef enum logic {
		OP_MAC,
		OP_DIV
	} alu_op_t;

	// mac: result = x + y * z over steps bits of z
	// div: remainder starts at x, divisor y, dividend bits from the top of z
	typedef struct packed {
		alu_op_t             op;
		logic [DATA_W-1:0]   x;
		logic [DATA_W-1:0]   y;
		logic [DATA_W-1:0]   z;
		logic [STEP_W-1:0]   steps;
	} alu_req_t;

endpackage

### hw/rtl/wse_alu.sv
// ----------------------------------------------------------------------------
// wse_alu
// Shared bit-serial unit: one 64-bit adder does shift-add multiply-accumulate
// and restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module wse_alu
	import wse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  alu_req_t          req,
	output logic              done,
	output logic [DATA_W-1:0] result
);

	typedef enum logic {
		A_IDLE,
		A_RUN
	} astate_t;

	astate_t           st_q;
	alu_op_t           op_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] b_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;

	logic [DATA_W-1:0] rem_shift;
	logic [DATA_W-1:0] opx;
	logic [DATA_W-1:0] opy;
	logic [DATA_W:0]   sum;
	logic              sat;

	assign rem_shift = {acc_q[DATA_W-2:0], b_q[DATA_W-1]};
	assign opx       = (op_q == OP_MAC) ? acc_q : rem_shift;
	assign opy       = (op_q == OP_MAC) ? (b_q[0] ? a_q : '0) : ~a_q;
	assign sum       = {1'b0, opx} + {1'b0, opy} + {{DATA_W{1'b0}}, (op_q == OP_DIV)};
	assign sat       = (req.op == OP_DIV) && (req.x >= req.y);

	assign done   = done_q;
	assign result = (op_q == OP_MAC) ? acc_q : b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			op_q   <= OP_MAC;
			acc_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				A_IDLE: begin
					if (start) begin
						op_q  <= req.op;
						acc_q <= req.x;
						a_q   <= req.y;
						b_q   <= req.z;
						cnt_q <= req.steps;
						if (sat) begin
							b_q    <= FRAC_ONE;
							done_q <= 1'b1;
						end else begin
							st_q <= A_RUN;
						end
					end
				end
				A_RUN: begin
					if (op_q == OP_MAC) begin
						acc_q <= sum[DATA_W-1:0];
						a_q   <= {a_q[DATA_W-2:0], 1'b0};
						b_q   <= {1'b0, b_q[DATA_W-1:1]};
					end else if (sum[DATA_W]) begin
						acc_q <= sum[DATA_W-1:0];
						b_q   <= {b_q[DATA_W-2:0], 1'b1};
					end else begin
						acc_q <= rem_shift;
						b_q   <= {b_q[DATA_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == STEP_W'(1)) begin
						st_q   <= A_IDLE;
						done_q <= 1'b1;
					end
				end
			endcase
		end
	end

endmodule

### hw/rtl/windowed_ssim_engine_core.sv
// ----------------------------------------------------------------------------
// windowed_ssim_engine_core
// Windowed SSIM over RGBA pixel pairs with per-window and image-mean results.
// ----------------------------------------------------------------------------
// A pixel pair takes longer in color mode than in luminance mode; a window end
// and an image end each add more work. All of it is set by the single
// bit-serial add/subtract unit, which retires one multiplier or quotient bit
// per cycle. in_ready is high only while the block waits for a pixel; a
// finished result sits in the output register while the next pixel is taken.
module windowed_ssim_engine_core
	import wse_pkg::*;
#(
	parameter int WINDOW_SIDE = 8,
	parameter int MAX_WINDOWS = 65536
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write_en,
	input  logic                    cfg_write_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              red_a,
	input  logic [7:0]              green_a,
	input  logic [7:0]              blue_a,
	input  logic [7:0]              alpha_a,
	input  logic [7:0]              red_b,
	input  logic [7:0]              green_b,
	input  logic [7:0]              blue_b,
	input  logic [7:0]              alpha_b,
	input  logic                    window_last,
	input  logic                    image_last,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] ssim_value,
	output logic                    result_kind,
	output logic                    last_of_run
);

	localparam int WIN_PIX = WINDOW_SIDE * WINDOW_SIDE;
	localparam int NW      = $clog2(WIN_PIX + 1);
	localparam int SUM_W   = COMP_W + NW;
	localparam int SQ_W    = 2 * COMP_W + NW;
	localparam int WS_W    = $clog2(MAX_WINDOWS + 1);
	localparam int ACC_W   = WS_W + OUT_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_PIX_SUM,
		S_FORM,
		S_EMIT_WIN,
		S_MEAN_PREP,
		S_EMIT_MEAN
	} state_t;

	typedef enum logic [4:0] {
		U_LUM_R, U_LUM_G, U_LUM_B, U_COL_MUL, U_COL_DIV,
		U_SQ_A, U_SQ_B, U_SQ_X,
		U_N2, U_C1N2, U_C2N2, U_NUM_L, U_DEN_LA, U_DEN_LB,
		U_CROSS_N, U_NSS_A, U_NSS_B, U_LUM_T, U_CON_T, U_PROD, U_MEAN
	} uop_t;

	state_t                  state_q;
	uop_t                    uop_q;
	logic                    side_q;
	logic                    cmp_q;
	logic [7:0]              ra_q, ga_q, ba_q, aa_q, rb_q, gb_q, bb_q, ab_q;
	logic                    img_q, win_q;
	logic [COMP_W-1:0]       ca_q, cb_q;
	logic [SUM_W-1:0]        sa_q, sb_q;
	logic [SQ_W-1:0]         ssa_q, ssb_q, sx_q;
	logic [NW-1:0]           pix_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [WS_W-1:0]         ws_q;
	logic [DATA_W-1:0]       t_q, n2_q, c1n2_q, c2n2_q, num_l_q, den_l_q;
	logic [DATA_W-1:0]       cn_q, nss_q, mag_q, den_c_q, lum_q, con_q, mean_x_q;
	logic                    neg_q;
	logic signed [OUT_W-1:0] s_q;
	logic [MEAN_W-1:0]       mean_q;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] out_value_q;
	logic                    out_kind_q;
	logic                    out_last_q;

	logic              alu_start;
	alu_req_t          alu_req;
	logic              alu_done;
	logic [DATA_W-1:0] alu_res;

	logic [7:0]        r_sel, g_sel, b_sel, a_sel;
	logic [9:0]        rgb_sum;
	logic [COMP_W-1:0] comp_res;
	logic [DATA_W-1:0] n_ext;
	logic [DATA_W-1:0] num_c;
	logic [OUT_W-1:0]  p_ext;
	logic signed [OUT_W-1:0] s_new;
	logic              out_free;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign ssim_value  = out_value_q;
	assign result_kind = out_kind_q;
	assign last_of_run = out_last_q;
	assign out_free    = !out_valid_q || out_ready;

	assign r_sel   = side_q ? rb_q : ra_q;
	assign g_sel   = side_q ? gb_q : ga_q;
	assign b_sel   = side_q ? bb_q : ba_q;
	assign a_sel   = side_q ? ab_q : aa_q;
	assign rgb_sum = {2'b0, r_sel} + {2'b0, g_sel} + {2'b0, b_sel};
	assign n_ext   = DATA_W'(pix_q);
	assign comp_res = (uop_q == U_COL_DIV) ? alu_res[CDIV_SHIFT+COMP_W-1:CDIV_SHIFT]
	                                       : {2'b0, alu_res[23:8]};
	assign num_c   = {cn_q[DATA_W-2:0], 1'b0} + c2n2_q + c1n2_q - num_l_q;
	assign p_ext   = {1'b0, alu_res[60:44]};
	assign s_new   = neg_q ? -$signed(p_ext) : $signed(p_ext);
	assign alu_start = (state_q == S_ISSUE);

	always_comb begin
		alu_req = '{op: OP_MAC, x: '0, y: '0, z: '0, steps: STEPS_BYTE};
		unique case (uop_q)
			U_LUM_R: begin
				alu_req.x = LUMA_RND; alu_req.y = LUMA_R; alu_req.z = DATA_W'(r_sel);
			end
			U_LUM_G: begin
				alu_req.x = t_q; alu_req.y = LUMA_G; alu_req.z = DATA_W'(g_sel);
			end
			U_LUM_B: begin
				alu_req.x = t_q; alu_req.y = LUMA_B; alu_req.z = DATA_W'(b_sel);
			end
			U_COL_MUL: begin
				alu_req.x = COLOR_RND;
				alu_req.y = DATA_W'(rgb_sum) << 8;
				alu_req.z = DATA_W'(a_sel);
			end
			U_COL_DIV: begin
				// divide by 255 as a reciprocal multiply, quotient above CDIV_SHIFT
				alu_req.y = COLOR_RECIP; alu_req.z = t_q; alu_req.steps = STEPS_CDIV;
			end
			U_SQ_A: begin
				alu_req.x = DATA_W'(ssa_q); alu_req.y = DATA_W'(ca_q);
				alu_req.z = DATA_W'(ca_q); alu_req.steps = STEPS_SQ;
			end
			U_SQ_B: begin
				alu_req.x = DATA_W'(ssb_q); alu_req.y = DATA_W'(cb_q);
				alu_req.z = DATA_W'(cb_q); alu_req.steps = STEPS_SQ;
			end
			U_SQ_X: begin
				alu_req.x = DATA_W'(sx_q); alu_req.y = DATA_W'(ca_q);
				alu_req.z = DATA_W'(cb_q); alu_req.steps = STEPS_SQ;
			end
			U_N2: begin
				alu_req.y = n_ext; alu_req.z = n_ext; alu_req.steps = STEP_W'(NW);
			end
			U_C1N2: begin
				alu_req.y = C1_Q16; alu_req.z = n2_q; alu_req.steps = STEP_W'(2 * NW);
			end
			U_C2N2: begin
				alu_req.y = C2_Q16; alu_req.z = n2_q; alu_req.steps = STEP_W'(2 * NW);
			end
			U_NUM_L: begin
				alu_req.x = c1n2_q; alu_req.y = DATA_W'(sa_q) << 1;
				alu_req.z = DATA_W'(sb_q); alu_req.steps = STEP_W'(SUM_W);
			end
			U_DEN_LA: begin
				alu_req.x = c1n2_q; alu_req.y = DATA_W'(sa_q);
				alu_req.z = DATA_W'(sa_q); alu_req.steps = STEP_W'(SUM_W);
			end
			U_DEN_LB: begin
				alu_req.x = den_l_q; alu_req.y = DATA_W'(sb_q);
				alu_req.z = DATA_W'(sb_q); alu_req.steps = STEP_W'(SUM_W);
			end
			U_CROSS_N: begin
				alu_req.y = DATA_W'(sx_q); alu_req.z = n_ext; alu_req.steps = STEP_W'(NW);
			end
			U_NSS_A: begin
				alu_req.y = DATA_W'(ssa_q); alu_req.z = n_ext; alu_req.steps = STEP_W'(NW);
			end
			U_NSS_B: begin
				alu_req.x = nss_q; alu_req.y = DATA_W'(ssb_q);
				alu_req.z = n_ext; alu_req.steps = STEP_W'(NW);
			end
			U_LUM_T: begin
				alu_req.op = OP_DIV; alu_req.x = num_l_q; alu_req.y = den_l_q;
				alu_req.steps = STEPS_FRAC;
			end
			U_CON_T: begin
				alu_req.op = OP_DIV; alu_req.x = mag_q; alu_req.y = den_c_q;
				alu_req.steps = STEPS_FRAC;
			end
			U_PROD: begin
				alu_req.x = PROD_RND; alu_req.y = lum_q; alu_req.z = con_q;
				alu_req.steps = STEPS_PROD;
			end
			U_MEAN: begin
				alu_req.op = OP_DIV; alu_req.y = DATA_W'(ws_q);
				alu_req.z = mean_x_q << MEAN_SHIFT; alu_req.steps = STEPS_MEAN;
			end
		endcase
	end

	wse_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (alu_start),
		.req    (alu_req),
		.done   (alu_done),
		.result (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			uop_q   <= U_LUM_R;
			side_q  <= 1'b0;
			cmp_q   <= 1'b0;
			{ra_q, ga_q, ba_q, aa_q, rb_q, gb_q, bb_q, ab_q} <= '0;
			img_q   <= 1'b0;
			win_q   <= 1'b0;
			ca_q    <= '0;
			cb_q    <= '0;
			sa_q    <= '0;
			sb_q    <= '0;
			ssa_q   <= '0;
			ssb_q   <= '0;
			sx_q    <= '0;
			pix_q   <= '0;
			acc_q   <= '0;
			ws_q    <= '0;
			t_q     <= '0;
			n2_q    <= '0;
			c1n2_q  <= '0;
			c2n2_q  <= '0;
			num_l_q <= '0;
			den_l_q <= '0;
			cn_q    <= '0;
			nss_q   <= '0;
			mag_q   <= '0;
			den_c_q <= '0;
			lum_q   <= '0;
			con_q   <= '0;
			mean_x_q <= '0;
			neg_q   <= 1'b0;
			s_q     <= '0;
			mean_q  <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_kind_q  <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				cmp_q <= cfg_write_data;
			end
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						{ra_q, ga_q, ba_q, aa_q} <= {red_a, green_a, blue_a, alpha_a};
						{rb_q, gb_q, bb_q, ab_q} <= {red_b, green_b, blue_b, alpha_b};
						img_q   <= image_last;
						win_q   <= window_last;
						side_q  <= 1'b0;
						uop_q   <= cmp_q ? U_COL_MUL : U_LUM_R;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (alu_done) begin
						state_q <= S_ISSUE;
						unique case (uop_q)
							U_LUM_R: begin t_q <= alu_res; uop_q <= U_LUM_G; end
							U_LUM_G: begin t_q <= alu_res; uop_q <= U_LUM_B; end
							U_COL_MUL: begin t_q <= alu_res; uop_q <= U_COL_DIV; end
							U_LUM_B, U_COL_DIV: begin
								if (!side_q) begin
									ca_q   <= comp_res;
									side_q <= 1'b1;
									uop_q  <= cmp_q ? U_COL_MUL : U_LUM_R;
								end else begin
									cb_q  <= comp_res;
									uop_q <= U_SQ_A;
								end
							end
							U_SQ_A: begin ssa_q <= alu_res[SQ_W-1:0]; uop_q <= U_SQ_B; end
							U_SQ_B: begin ssb_q <= alu_res[SQ_W-1:0]; uop_q <= U_SQ_X; end
							U_SQ_X: begin
								sx_q    <= alu_res[SQ_W-1:0];
								state_q <= S_PIX_SUM;
							end
							U_N2: begin n2_q <= alu_res; uop_q <= U_C1N2; end
							U_C1N2: begin c1n2_q <= alu_res; uop_q <= U_C2N2; end
							U_C2N2: begin c2n2_q <= alu_res; uop_q <= U_NUM_L; end
							U_NUM_L: begin num_l_q <= alu_res; uop_q <= U_DEN_LA; end
							U_DEN_LA: begin den_l_q <= alu_res; uop_q <= U_DEN_LB; end
							U_DEN_LB: begin den_l_q <= alu_res; uop_q <= U_CROSS_N; end
							U_CROSS_N: begin cn_q <= alu_res; uop_q <= U_NSS_A; end
							U_NSS_A: begin nss_q <= alu_res; uop_q <= U_NSS_B; end
							U_NSS_B: begin
								nss_q   <= alu_res;
								state_q <= S_FORM;
							end
							U_LUM_T: begin lum_q <= alu_res; uop_q <= U_CON_T; end
							U_CON_T: begin con_q <= alu_res; uop_q <= U_PROD; end
							U_PROD: begin
								s_q <= s_new;
								if (ws_q < WS_W'(MAX_WINDOWS)) begin
									acc_q <= acc_q + {{(ACC_W-OUT_W){s_new[OUT_W-1]}}, s_new};
									ws_q  <= ws_q + 1'b1;
								end
								sa_q    <= '0;
								sb_q    <= '0;
								ssa_q   <= '0;
								ssb_q   <= '0;
								sx_q    <= '0;
								pix_q   <= '0;
								state_q <= S_EMIT_WIN;
							end
							U_MEAN: begin
								mean_q  <= (alu_res > MEAN_MAX) ? MEAN_MAX[MEAN_W-1:0]
								                                : alu_res[MEAN_W-1:0];
								state_q <= S_EMIT_MEAN;
							end
						endcase
					end
				end
				S_PIX_SUM: begin
					sa_q  <= sa_q + SUM_W'(ca_q);
					sb_q  <= sb_q + SUM_W'(cb_q);
					pix_q <= pix_q + 1'b1;
					if (win_q || img_q || (NW'(pix_q + 1'b1) >= NW'(WIN_PIX))) begin
						uop_q   <= U_N2;
						state_q <= S_ISSUE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FORM: begin
					neg_q   <= num_c[DATA_W-1];
					mag_q   <= num_c[DATA_W-1] ? (~num_c + 1'b1) : num_c;
					den_c_q <= nss_q + c1n2_q + c2n2_q - den_l_q;
					uop_q   <= U_LUM_T;
					state_q <= S_ISSUE;
				end
				S_EMIT_WIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= s_q;
						out_kind_q  <= 1'b0;
						out_last_q  <= !img_q;
						state_q     <= img_q ? S_MEAN_PREP : S_IDLE;
					end
				end
				S_MEAN_PREP: begin
					if (acc_q[ACC_W-1] || (acc_q == '0) || (ws_q == '0)) begin
						mean_q  <= '0;
						state_q <= S_EMIT_MEAN;
					end else begin
						mean_x_q <= DATA_W'(acc_q[ACC_W-2:0]) + DATA_W'(ws_q >> 1);
						uop_q    <= U_MEAN;
						state_q  <= S_ISSUE;
					end
				end
				S_EMIT_MEAN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= $signed({1'b0, mean_q});
						out_kind_q  <= 1'b1;
						out_last_q  <= 1'b1;
						acc_q       <= '0;
						ws_q        <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
